@@ rtl/pfde_pkg.sv @@
// Shared types, constants and helpers of the page frame buffer draw engine.
`timescale 1ns / 1ps

package pfde_pkg;

  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;

  // Widths that cover the largest screen the block supports.
  localparam int ADDR_W = 16;
  localparam int COL_W  = 11;
  localparam int ROW_W  = 10;
  localparam int REM_W  = 10;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 8;

  localparam logic [2:0] OP_CURSOR = 3'd0;
  localparam logic [2:0] OP_FILL   = 3'd1;
  localparam logic [2:0] OP_PIXEL  = 3'd2;
  localparam logic [2:0] OP_RECT   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [1:0] COLOR_WHITE = 2'd0;
  localparam logic [1:0] COLOR_BLACK = 2'd1;

  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZEROS = 8'h00;

  // What the back end has to do for one word.
  typedef enum logic [2:0] {
    KIND_NOP   = 3'd0,
    KIND_FILL  = 3'd1,
    KIND_PIXEL = 3'd2,
    KIND_RECT  = 3'd3,
    KIND_READ  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               black;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  base;
    logic [7:0]         mask;
    logic [COL_W-1:0]   col_start;
    logic [COL_W-1:0]   col_end;
    logic [ROW_W-1:0]   row;
    logic [REM_W-1:0]   rem;
  } cmd_t;

  // Rows of one page covered by a rectangle that starts at row offset off
  // and still has rem rows to go.
  function automatic logic [7:0] page_mask(input logic [2:0] off,
                                           input logic [REM_W-1:0] rem);
    logic [7:0] m;
    if (rem >= REM_W'(8)) begin
      m = BYTE_ONES;
    end else begin
      m = (8'd1 << rem[2:0]) - 8'd1;
    end
    return m << off;
  endfunction

endpackage

@@ rtl/pfde_front.sv @@
// Command front end: takes input words, keeps the cursor and classifies commands.
`timescale 1ns / 1ps

module pfde_front import pfde_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   q_full,
  input  logic                   clearing,
  output logic                   q_push,
  output cmd_t                   q_cmd
);

  localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
  localparam int CCW         = $clog2(SCREEN_WIDTH + 1);
  localparam int CRW         = $clog2(SCREEN_HEIGHT + 1);

  logic [CCW-1:0] cur_col_r, cur_col_nxt;
  logic [CRW-1:0] cur_row_r, cur_row_nxt;

  logic [2:0]  op;
  logic [9:0]  pos_x, pos_y, rect_width, rect_height, read_index;
  logic [1:0]  color;
  logic        color_ok;
  logic        accept;
  logic [11:0] col_sum, col_end;
  logic        rect_empty;
  logic [ADDR_W-1:0] page_base;

  assign op          = in_tuser;
  assign pos_x       = in_tdata[9:0];
  assign pos_y       = in_tdata[19:10];
  assign rect_width  = in_tdata[29:20];
  assign rect_height = in_tdata[39:30];
  assign color       = in_tdata[41:40];
  assign read_index  = in_tdata[51:42];

  assign in_tready = !q_full && !clearing;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept;
  assign color_ok  = (color == COLOR_BLACK) || (color == COLOR_WHITE);

  assign col_sum = 12'(cur_col_r) + 12'(rect_width);
  assign col_end = (col_sum > 12'(SCREEN_WIDTH)) ? 12'(SCREEN_WIDTH) : col_sum;
  assign rect_empty = (rect_width == '0) || (rect_height == '0) ||
                      (12'(cur_col_r) >= 12'(SCREEN_WIDTH)) ||
                      (12'(cur_row_r) >= 12'(SCREEN_HEIGHT));
  assign page_base = ADDR_W'(32'(cur_row_r >> 3) * 32'(SCREEN_WIDTH));

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    q_cmd       = '0;
    q_cmd.kind  = KIND_NOP;
    q_cmd.black = (color == COLOR_BLACK);
    case (op)
      OP_CURSOR: begin
        if (accept) begin
          cur_col_nxt = (11'(pos_x) > 11'(SCREEN_WIDTH)) ? CCW'(SCREEN_WIDTH) : CCW'(pos_x);
          cur_row_nxt = (11'(pos_y) > 11'(SCREEN_HEIGHT)) ? CRW'(SCREEN_HEIGHT) : CRW'(pos_y);
        end
      end
      OP_FILL: begin
        if (color_ok) begin
          q_cmd.kind = KIND_FILL;
        end
      end
      OP_PIXEL: begin
        if (color_ok && (12'(pos_x) < 12'(SCREEN_WIDTH)) &&
            (12'(pos_y) < 12'(SCREEN_HEIGHT))) begin
          q_cmd.kind      = KIND_PIXEL;
          q_cmd.addr      = ADDR_W'(32'(pos_y[9:3]) * 32'(SCREEN_WIDTH) + 32'(pos_x));
          q_cmd.mask      = 8'd1 << pos_y[2:0];
          q_cmd.col_start = '0;
          q_cmd.col_end   = COL_W'(1);
          q_cmd.rem       = '0;
        end
      end
      OP_RECT: begin
        if (color_ok && !rect_empty) begin
          q_cmd.kind      = KIND_RECT;
          q_cmd.base      = page_base;
          q_cmd.addr      = page_base + ADDR_W'(cur_col_r);
          q_cmd.col_start = COL_W'(cur_col_r);
          q_cmd.col_end   = COL_W'(col_end);
          q_cmd.row       = ROW_W'(cur_row_r);
          q_cmd.rem       = rect_height;
          q_cmd.mask      = page_mask(3'(cur_row_r), rect_height);
        end
      end
      OP_READ: begin
        if (32'(read_index) < 32'(STORE_BYTES)) begin
          q_cmd.kind = KIND_READ;
          q_cmd.addr = ADDR_W'(read_index);
        end
      end
      default: begin
        q_cmd.kind = KIND_NOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
    end else begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
    end
  end

endmodule

@@ rtl/pfde_queue.sv @@
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module pfde_queue import pfde_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  cmd_t       slots_r [2];

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("command queue count out of range");
`endif

endmodule

@@ rtl/pfde_back.sv @@
// Command back end: owns the page buffer and carries out fills, pixels, rectangles and reads.
`timescale 1ns / 1ps

module pfde_back import pfde_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  cmd_t                    q_cmd,
  output logic                    q_pop,
  output logic                    clearing,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata
);

  localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_FILL  = 6'b000100,
    S_RUN   = 6'b001000,
    S_DRAIN = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] col_start_r, col_start_nxt;
  logic [COL_W-1:0] col_end_r, col_end_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [7:0]       mask_r, mask_nxt;
  logic             black_r, black_nxt;
  logic             read_r, read_nxt;
  logic             wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]    wr_addr_r, wr_addr_nxt;
  logic [7:0]       wr_mask_r, wr_mask_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r, out_data_nxt;

  logic [7:0]       mem [STORE_BYTES];
  logic [7:0]       rd_data_r;
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [7:0]       wr_data;

  logic [3:0]       step;
  logic [10:0]      row_step;
  logic [AW-1:0]    next_base;

  assign clearing   = (state_r == S_CLEAR);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A page ends at the next multiple of eight rows.
  assign step      = 4'd8 - {1'b0, row_r[2:0]};
  assign row_step  = {1'b0, row_r} + 11'(step);
  assign next_base = base_r + AW'(SCREEN_WIDTH);

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    base_nxt      = base_r;
    col_nxt       = col_r;
    col_start_nxt = col_start_r;
    col_end_nxt   = col_end_r;
    row_nxt       = row_r;
    rem_nxt       = rem_r;
    mask_nxt      = mask_r;
    black_nxt     = black_r;
    read_nxt      = read_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    wr_mask_nxt   = wr_mask_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = addr_r;

    // The byte read last cycle is written back with the mask applied.
    wr_en   = wr_pend_r;
    wr_addr = wr_addr_r;
    wr_data = black_r ? (rd_data_r | wr_mask_r) : (rd_data_r & ~wr_mask_r);

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = addr_r;
        wr_data = BYTE_ZEROS;
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          black_nxt = q_cmd.black;
          read_nxt  = (q_cmd.kind == KIND_READ);
          case (q_cmd.kind)
            KIND_FILL: begin
              addr_nxt  = '0;
              state_nxt = S_FILL;
            end
            KIND_PIXEL, KIND_RECT: begin
              addr_nxt      = q_cmd.addr[AW-1:0];
              base_nxt      = q_cmd.base[AW-1:0];
              col_nxt       = q_cmd.col_start;
              col_start_nxt = q_cmd.col_start;
              col_end_nxt   = q_cmd.col_end;
              row_nxt       = q_cmd.row;
              rem_nxt       = q_cmd.rem;
              mask_nxt      = q_cmd.mask;
              state_nxt     = S_RUN;
            end
            KIND_READ: begin
              rd_en     = 1'b1;
              rd_addr   = q_cmd.addr[AW-1:0];
              state_nxt = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_FILL: begin
        wr_en   = 1'b1;
        wr_addr = addr_r;
        wr_data = black_r ? BYTE_ONES : BYTE_ZEROS;
        if (addr_r == LAST_ADDR) begin
          state_nxt = S_RESP;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      S_RUN: begin
        rd_en       = 1'b1;
        rd_addr     = addr_r;
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = addr_r;
        wr_mask_nxt = mask_r;
        if (col_r + COL_W'(1) == col_end_r) begin
          if ((rem_r > REM_W'(step)) && (row_step < 11'(SCREEN_HEIGHT))) begin
            row_nxt  = ROW_W'(row_step);
            rem_nxt  = rem_r - REM_W'(step);
            base_nxt = next_base;
            addr_nxt = next_base + AW'(col_start_r);
            col_nxt  = col_start_r;
            mask_nxt = page_mask(3'd0, rem_r - REM_W'(step));
          end else begin
            state_nxt = S_DRAIN;
          end
        end else begin
          col_nxt  = col_r + COL_W'(1);
          addr_nxt = addr_r + AW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = read_r ? rd_data_r : BYTE_ZEROS;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    col_r       <= col_nxt;
    col_start_r <= col_start_nxt;
    col_end_r   <= col_end_nxt;
    row_r       <= row_nxt;
    rem_r       <= rem_nxt;
    mask_r      <= mask_nxt;
    black_r     <= black_nxt;
    read_r      <= read_nxt;
    wr_addr_r   <= wr_addr_nxt;
    wr_mask_r   <= wr_mask_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

`ifndef SYNTH
  a_wb_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (state_r == S_RUN || state_r == S_DRAIN))
    else $error("buffer write-back outside a pixel or rectangle walk");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("buffer read and write hit the same byte");

  a_resp_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_valid_r && !out_tready) |=> (state_r == S_RESP))
    else $error("result dropped while the output word was stalled");
`endif

endmodule

@@ rtl/page_framebuffer_draw_engine.sv @@
// Top level of the monochrome page frame buffer draw engine.
`timescale 1ns / 1ps

// The buffer holds SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8) bytes, one byte per
// column of an eight-row page with bit 0 on top. After reset the block runs a
// clearing pass of one byte per cycle and accepts no word until it is done.
// Every command returns exactly one output word, the buffer byte for a read
// and zero otherwise. A two-word queue sits between the input and the buffer
// engine, so input words keep being taken, while the queue has room, as
// earlier commands run or a result waits. The buffer has one write and one
// read per cycle, and that port sets the cost: a fill writes every byte of
// the buffer; a pixel or rectangle reads each touched byte and writes it back.
module page_framebuffer_draw_engine import pfde_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // pos_x[9:0], pos_y[19:10], rect_width[29:20], rect_height[39:30],
  // color[41:40], read_index[51:42], zero pad[55:52]
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  // op[2:0]
  input  logic [IN_TUSER_W-1:0]   in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // read_data[7:0]
  output logic [OUT_TDATA_W-1:0]  out_tdata
);

  logic q_push, q_full, q_pop, q_valid, clearing;
  cmd_t push_cmd, head_cmd;

  pfde_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .clearing  (clearing),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  pfde_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  pfde_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
